[rtl/mot_pkg.sv]
// ----------------------------------------------------------------------------
// mot_pkg - shared types and constants
// Field widths, scaling constants and the words passed between the
// accumulator and the temperature scaler.
// ----------------------------------------------------------------------------
package mot_pkg;

    localparam int SAMPLE_W = 10;
    localparam int CH_W     = 2;
    localparam int TEMP_W   = 14;
    localparam int SUM_W    = 16;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // temperature = sum * 11000 / (1024 * samples per average)
    localparam int SCALE_NUM_W                 = 14;
    localparam logic [SCALE_NUM_W-1:0] SCALE_NUM = 14'd11000;
    localparam int SCALE_DEN_SHIFT             = 10;

    // scaled sum after the power-of-two part of the divide
    localparam int Q_W         = SUM_W + SCALE_NUM_W - SCALE_DEN_SHIFT;
    // reciprocal precision, exact for Q_W-bit dividends and 8-bit divisors
    localparam int RECIP_SHIFT = Q_W + 8;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0]  mux_channel;
        logic             block_done;
        logic [SUM_W-1:0] sum;
    } t_acc_word;

    typedef struct packed {
        logic load_b;
        logic load_c;
    } t_pipe_en;

endpackage

[rtl/mot_in_if.sv]
// ----------------------------------------------------------------------------
// mot_in_if - input channel
// Sample or query word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mot_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [mot_pkg::SAMPLE_W-1:0]  sample;
    logic [mot_pkg::CH_W-1:0]      query_channel;

    modport source (output valid, kind, sample, query_channel, input ready);
    modport sink   (input valid, kind, sample, query_channel, output ready);
endinterface

[rtl/mot_out_if.sv]
// ----------------------------------------------------------------------------
// mot_out_if - result channel
// Multiplexer channel, block done flag and temperature with valid/ready.
// ----------------------------------------------------------------------------
interface mot_out_if;
    logic                         valid;
    logic                         ready;
    logic [mot_pkg::CH_W-1:0]     mux_channel;
    logic                         block_done;
    logic [mot_pkg::TEMP_W-1:0]   temperature;

    modport source (output valid, mux_channel, block_done, temperature, input ready);
    modport sink   (input valid, mux_channel, block_done, temperature, output ready);
endinterface

[rtl/mot_acc.sv]
// ----------------------------------------------------------------------------
// mot_acc - oversampling accumulator and per-channel sum table
// Holds the running sum, sample count, round-robin channel and stored sums;
// produces the unscaled result word for each accepted input word.
// ----------------------------------------------------------------------------
module mot_acc #(
    parameter int CHANNELS            = 4,
    parameter int SAMPLES_PER_AVERAGE = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_kind,
    input  logic [mot_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [mot_pkg::CH_W-1:0]      i_query_channel,
    output mot_pkg::t_acc_word            o_word
);

    localparam int SUM_W    = mot_pkg::SUM_W;
    localparam int CH_W     = mot_pkg::CH_W;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W    = $clog2(SAMPLES_PER_AVERAGE + 1);

    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_cnt;
    logic [CH_IDX_W-1:0] r_chan;
    logic [SUM_W-1:0]    r_table [CHANNELS];

    logic [SUM_W-1:0]    n_sum;
    logic [CNT_W-1:0]    n_cnt;
    logic [CH_IDX_W-1:0] n_chan;

    logic [SUM_W:0]      sum_ext;
    logic [SUM_W-1:0]    sum_sat;
    logic                last_smp;
    logic [CH_IDX_W-1:0] chan_wrap;
    logic                q_hit;
    logic [SUM_W-1:0]    q_sum;
    logic                is_smp;
    logic                store;
    logic [CH_W-1:0]     chan_now;
    logic [CH_W-1:0]     chan_after;

    always_comb begin
        is_smp    = (i_kind == mot_pkg::KIND_SAMPLE);
        sum_ext   = {1'b0, r_sum} + (SUM_W+1)'(i_sample);
        sum_sat   = sum_ext[SUM_W] ? mot_pkg::SUM_MAX : sum_ext[SUM_W-1:0];
        last_smp  = (r_cnt == CNT_W'(SAMPLES_PER_AVERAGE - 1));
        chan_wrap = (r_chan == CH_IDX_W'(CHANNELS - 1)) ? '0 : r_chan + 1'b1;
        q_hit     = (int'(i_query_channel) < CHANNELS);
        q_sum     = q_hit ? r_table[CH_IDX_W'(i_query_channel)] : '0;
        store     = i_accept && is_smp && last_smp;
        chan_now   = CH_W'(r_chan);
        chan_after = CH_W'(chan_wrap);

        n_sum  = r_sum;
        n_cnt  = r_cnt;
        n_chan = r_chan;
        if (i_accept && is_smp) begin
            if (last_smp) begin
                n_sum  = '0;
                n_cnt  = '0;
                n_chan = chan_wrap;
            end else begin
                n_sum  = sum_sat;
                n_cnt  = r_cnt + 1'b1;
            end
        end

        if (is_smp) begin
            o_word.mux_channel = last_smp ? chan_after : chan_now;
            o_word.block_done  = last_smp;
            o_word.sum         = '0;
        end else begin
            o_word.mux_channel = chan_now;
            o_word.block_done  = 1'b0;
            o_word.sum         = q_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_cnt  <= '0;
            r_chan <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_table[i] <= '0;
            end
        end else begin
            r_sum  <= n_sum;
            r_cnt  <= n_cnt;
            r_chan <= n_chan;
            for (int i = 0; i < CHANNELS; i++) begin
                if (store && (r_chan == CH_IDX_W'(i))) begin
                    r_table[i] <= sum_sat;
                end
            end
        end
    end

endmodule

[rtl/mot_scale.sv]
// ----------------------------------------------------------------------------
// mot_scale - two-stage temperature scaler
// Multiplies the stored sum by 11000, drops the 1024 divisor, then divides
// by the block length through a reciprocal multiply.
// ----------------------------------------------------------------------------
module mot_scale #(
    parameter int SAMPLES_PER_AVERAGE = 64
) (
    input  logic                        i_clk,
    input  mot_pkg::t_pipe_en           i_en,
    input  mot_pkg::t_acc_word          i_word,
    output logic [mot_pkg::CH_W-1:0]    o_mux_channel,
    output logic                        o_block_done,
    output logic [mot_pkg::TEMP_W-1:0]  o_temperature
);

    localparam int SUM_W       = mot_pkg::SUM_W;
    localparam int Q_W         = mot_pkg::Q_W;
    localparam int CH_W        = mot_pkg::CH_W;
    localparam int TEMP_W      = mot_pkg::TEMP_W;
    localparam int DEN_SHIFT   = mot_pkg::SCALE_DEN_SHIFT;
    localparam int RECIP_SHIFT = mot_pkg::RECIP_SHIFT;
    localparam int PROD_B_W    = SUM_W + mot_pkg::SCALE_NUM_W;

    // ceil(2^RECIP_SHIFT / samples per average)
    localparam longint unsigned RecipMul =
        ((64'd1 << RECIP_SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
    localparam int MUL_W    = $clog2(RecipMul + 1);
    localparam int PROD_C_W = Q_W + MUL_W;

    localparam logic [MUL_W-1:0] RECIP = MUL_W'(RecipMul);

    logic [PROD_B_W-1:0] prod_b;
    logic [PROD_C_W-1:0] prod_c;

    logic [Q_W-1:0]      r_q;
    logic [CH_W-1:0]     r_mux_b;
    logic                r_done_b;
    logic [TEMP_W-1:0]   r_temp;
    logic [CH_W-1:0]     r_mux_c;
    logic                r_done_c;

    assign prod_b = PROD_B_W'(i_word.sum) * PROD_B_W'(mot_pkg::SCALE_NUM);
    assign prod_c = PROD_C_W'(r_q) * PROD_C_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en.load_b) begin
            r_q      <= prod_b[PROD_B_W-1:DEN_SHIFT];
            r_mux_b  <= i_word.mux_channel;
            r_done_b <= i_word.block_done;
        end
        if (i_en.load_c) begin
            r_temp   <= TEMP_W'(prod_c >> RECIP_SHIFT);
            r_mux_c  <= r_mux_b;
            r_done_c <= r_done_b;
        end
    end

    assign o_mux_channel = r_mux_c;
    assign o_block_done  = r_done_c;
    assign o_temperature = r_temp;

endmodule

[rtl/multichannel_oversample_thermometer.sv]
// ----------------------------------------------------------------------------
// multichannel_oversample_thermometer - round-robin oversampling thermometer
// Accumulates converter samples per channel and answers temperature queries.
// ----------------------------------------------------------------------------
// usage
//   i_in carries one word per handshake: kind 0 is a converter sample, kind 1
//   a temperature query for query_channel. every accepted word yields exactly
//   one word on o_out, in order.
//   a sample word reports the channel the multiplexer should select next and
//   block_done when it closed a block of SAMPLES_PER_AVERAGE samples; its
//   temperature is 0. a query word reports the stored average of the named
//   channel in hundredths of a degree (0 for a channel beyond CHANNELS).
//   three register stages: table read, the x11000 multiply, then the
//   reciprocal multiply for the block length. o_out.valid rises when a word
//   reaches the third stage, after the first two. throughput is one word per
//   cycle unless o_out stalls; the three stages advance as one pipeline with
//   per-stage valid bits, so bubbles are squeezed out.
//   when o_out stalls, the result stays in the output register and earlier
//   stages keep filling until all three hold a word; only then i_in.ready drops.
//   reset (synchronous, active low) clears the running sum, the count, the
//   channel pointer and all stored sums, and empties the pipeline.
// ----------------------------------------------------------------------------
module multichannel_oversample_thermometer #(
    parameter int CHANNELS            = 4,
    parameter int SAMPLES_PER_AVERAGE = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mot_in_if.sink     i_in,
    mot_out_if.source  o_out
);

    // stage valid bits: a = table read, b = first multiply, c = result
    logic r_valid_a;
    logic r_valid_b;
    logic r_valid_c;

    logic en_a;
    logic en_b;
    logic en_c;
    logic accept;

    mot_pkg::t_acc_word acc_word;
    mot_pkg::t_acc_word r_word_a;
    mot_pkg::t_pipe_en  pipe_en;

    // a stage moves when it is empty or the stage after it moves
    assign en_c   = !r_valid_c || o_out.ready;
    assign en_b   = !r_valid_b || en_c;
    assign en_a   = !r_valid_a || en_b;
    assign accept = i_in.valid && en_a;

    assign i_in.ready = en_a;

    assign pipe_en.load_b = en_b;
    assign pipe_en.load_c = en_c;

    // state update happens at acceptance, so later words see it at once
    mot_acc #(
        .CHANNELS            (CHANNELS),
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
    ) u_acc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_kind          (i_in.kind),
        .i_sample        (i_in.sample),
        .i_query_channel (i_in.query_channel),
        .o_word          (acc_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
            r_valid_c <= 1'b0;
        end else begin
            if (en_a) begin
                r_valid_a <= i_in.valid;
            end
            if (en_b) begin
                r_valid_b <= r_valid_a;
            end
            if (en_c) begin
                r_valid_c <= r_valid_b;
            end
        end
    end

    // payload of stage a, no reset needed
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_word_a <= acc_word;
        end
    end

    mot_scale #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
    ) u_scale (
        .i_clk         (i_clk),
        .i_en          (pipe_en),
        .i_word        (r_word_a),
        .o_mux_channel (o_out.mux_channel),
        .o_block_done  (o_out.block_done),
        .o_temperature (o_out.temperature)
    );

    assign o_out.valid = r_valid_c;

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb - testbench for multichannel_oversample_thermometer
// Feeds sample and query words through the input channel with random gaps,
// predicts every result word from its own copy of the accumulator and the
// stored sums, and checks each word on the result channel against it in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int     CH_N         = 4;
    localparam int     BLOCK_LEN    = 64;
    localparam longint DEGREE_SCALE = 11000;
    localparam longint ADC_SPAN     = 1024;
    localparam int     SUM_LIMIT    = 65535;
    localparam int     PIPE_LATENCY = 3;
    localparam int     IDLE_PCT     = 27;
    localparam int     RANDOM_WORDS = 675;

    typedef struct packed {
        logic [mot_pkg::CH_W-1:0]   mux_channel;
        logic                       block_done;
        logic [mot_pkg::TEMP_W-1:0] temperature;
    } t_reading;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mot_in_if  in_if ();
    mot_out_if out_if ();

    multichannel_oversample_thermometer #(
        .CHANNELS            (CH_N),
        .SAMPLES_PER_AVERAGE (BLOCK_LEN)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #10 i_clk = ~i_clk;

    // predicted state of the accumulator and the per-channel table
    int unsigned                acc_sum;
    int unsigned                acc_count;
    int unsigned                cur_ch;
    logic [mot_pkg::SUM_W-1:0]  stored_sums [CH_N];

    t_reading pending_readings [$];
    int       mismatch_count = 0;
    // when set neither side idles
    bit       steady_flow = 1'b0;

    function automatic void clear_thermo_state();
        acc_sum   = 0;
        acc_count = 0;
        cur_ch    = 0;
        foreach (stored_sums[i]) stored_sums[i] = '0;
    endfunction

    // advance the predicted state by one accepted word, return its reading
    function automatic t_reading thermo_step(logic kind, logic [mot_pkg::SAMPLE_W-1:0] s,
                                             logic [mot_pkg::CH_W-1:0] q);
        t_reading r;
        r = '0;
        if (kind == mot_pkg::KIND_SAMPLE) begin
            acc_sum = acc_sum + s;
            // saturate, only reachable with long blocks
            if (acc_sum > SUM_LIMIT) acc_sum = SUM_LIMIT;
            acc_count++;
            if (acc_count >= BLOCK_LEN) begin
                if (cur_ch < CH_N) stored_sums[cur_ch] = acc_sum[mot_pkg::SUM_W-1:0];
                acc_sum   = 0;
                acc_count = 0;
                cur_ch    = (cur_ch + 1) % CH_N;
                r.block_done = 1'b1;
            end
        end else if (q < CH_N) begin
            // hundredths of a degree, truncating
            r.temperature = mot_pkg::TEMP_W'(longint'(stored_sums[q]) * DEGREE_SCALE
                                             / (ADC_SPAN * BLOCK_LEN));
        end
        // query words report the unchanged channel
        r.mux_channel = mot_pkg::CH_W'(cur_ch);
        return r;
    endfunction

    // drive one word, wait for the handshake, then record its reading
    task automatic send_word(input logic kind, input logic [mot_pkg::SAMPLE_W-1:0] s,
                             input logic [mot_pkg::CH_W-1:0] q);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.kind          <= kind;
        in_if.sample        <= s;
        in_if.query_channel <= q;
        do @(posedge i_clk); while (!in_if.ready);
        pending_readings.push_back(thermo_step(kind, s, q));
    endtask

    task automatic send_block(input logic [mot_pkg::SAMPLE_W-1:0] a,
                              input logic [mot_pkg::SAMPLE_W-1:0] b);
        for (int i = 0; i < BLOCK_LEN; i++) send_word(mot_pkg::KIND_SAMPLE, (i % 2) ? b : a, '0);
    endtask

    task automatic query_all();
        for (int c = 0; c < 4; c++) send_word(mot_pkg::KIND_QUERY, '0, mot_pkg::CH_W'(c));
    endtask

    // hold off the sender until the pipeline has handed back everything
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    // table is all zero after reset, channel pointer at zero
    task automatic test_reset_state();
        query_all();
        send_word(mot_pkg::KIND_QUERY, '1, '1);
    endtask

    // full-scale block gives the top temperature, an all-zero block gives 0
    task automatic test_full_scale_blocks();
        send_block('1, '1);
        send_word(mot_pkg::KIND_QUERY, '0, 2'd0);
        send_block('0, '0);
        query_all();
        // sample field is ignored on queries
        send_word(mot_pkg::KIND_QUERY, 10'h3ff, 2'd1);
    endtask

    // two more blocks bring the pointer back around to channel zero;
    // a query in the middle of a block leaves the channel alone
    task automatic test_channel_wrap();
        send_block(10'd1, 10'd1022);
        for (int i = 0; i < BLOCK_LEN; i++) begin
            if (i == BLOCK_LEN / 2) send_word(mot_pkg::KIND_QUERY, '0, 2'd2);
            send_word(mot_pkg::KIND_SAMPLE, 10'd512, '1);
        end
        query_all();
        send_word(mot_pkg::KIND_SAMPLE, 10'h155, '0);
        send_word(mot_pkg::KIND_SAMPLE, 10'h2aa, '0);
        send_word(mot_pkg::KIND_QUERY, '0, 2'd3);
    endtask

    // mostly samples clustered around a level that changes every block,
    // so the stored sums cover the whole range; queries mixed in at random
    task automatic test_random_traffic();
        int level;
        int v;
        logic [mot_pkg::SAMPLE_W-1:0] s;
        level = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            steady_flow = (n >= 300 && n < 480);
            if (n == 620) drain_results();
            if ($urandom_range(99) < 15) begin
                send_word(mot_pkg::KIND_QUERY, mot_pkg::SAMPLE_W'($urandom),
                          mot_pkg::CH_W'($urandom));
            end else begin
                if (acc_count == 0) level = $urandom_range(1023);
                case ($urandom_range(9))
                    0: s = '0;
                    1: s = '1;
                    2: s = mot_pkg::SAMPLE_W'($urandom);
                    default: begin
                        v = level + int'($urandom_range(30)) - 15;
                        if (v < 0) v = 0;
                        if (v > 1023) v = 1023;
                        s = mot_pkg::SAMPLE_W'(v);
                    end
                endcase
                send_word(mot_pkg::KIND_SAMPLE, s, mot_pkg::CH_W'($urandom));
            end
        end
        steady_flow = 1'b0;
    endtask

    // result side: ready drops at random, never during the steady stretch
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // compare every accepted result word with the oldest prediction
    always @(posedge i_clk) begin : check_readings
        t_reading want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_readings.size() == 0) begin
                $error("result word with no prediction waiting");
                mismatch_count++;
            end else begin
                want = pending_readings.pop_front();
                if (out_if.mux_channel !== want.mux_channel) begin
                    $error("mux_channel: expected %0d, got %0d",
                           want.mux_channel, out_if.mux_channel);
                    mismatch_count++;
                end
                if (out_if.block_done !== want.block_done) begin
                    $error("block_done: expected %0d, got %0d",
                           want.block_done, out_if.block_done);
                    mismatch_count++;
                end
                if (out_if.temperature !== want.temperature) begin
                    $error("temperature: expected %0d, got %0d",
                           want.temperature, out_if.temperature);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        in_if.valid         <= 1'b0;
        in_if.kind          <= mot_pkg::KIND_SAMPLE;
        in_if.sample        <= '0;
        in_if.query_channel <= '0;
        i_rst_n             <= 1'b0;
        clear_thermo_state();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_full_scale_blocks();
        test_channel_wrap();
        test_random_traffic();

        drain_results();
        if (pending_readings.size() != 0) begin
            $error("%0d predicted words never arrived", pending_readings.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("** multichannel_oversample_thermometer: PASSED **");
        end else begin
            $display("** multichannel_oversample_thermometer: FAILED **");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("** multichannel_oversample_thermometer: FAILED **");
        $finish;
    end

endmodule

[files.f]
rtl/mot_pkg.sv
rtl/mot_in_if.sv
rtl/mot_out_if.sv
rtl/mot_acc.sv
rtl/mot_scale.sv
rtl/multichannel_oversample_thermometer.sv
tb/sv/tb.sv
